// File: sv/fcs_pkg.sv
// Package for the flash command sequencer: types, command codes, geometry constants.
// No dependencies; imported by the interface users, the top level and the checker.

package fcs_pkg;

	localparam int ADDRESS_BITS_DEF = 21;
	localparam int ADDR_W           = 21;
	localparam int DATA_W           = 8;
	localparam int LEN_W            = 17;
	localparam int CFG_IDX_W        = 1;
	localparam int CFG_DATA_W       = 8;

	typedef enum logic [2:0] {
		ST_READ    = 3'd0,
		ST_UNLOCK1 = 3'd1,
		ST_UNLOCK2 = 3'd2,
		ST_COMMAND = 3'd3,
		ST_ID      = 3'd4,
		ST_PROGRAM = 3'd5,
		ST_ERASED  = 3'd6,
		ST_PROTECT = 3'd7
	} state_t;

	typedef enum logic [1:0] {
		PFX_NONE = 2'd0,
		PFX_80   = 2'd1,
		PFX_9A   = 2'd2
	} prefix_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_AND  = 2'd1,
		OP_FILL = 2'd2
	} mem_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHIP_PRESENT = 1'b0,
		CFG_DEVICE_CODE  = 1'b1
	} cfg_idx_t;

	localparam logic [DATA_W-1:0] DEVICE_CODE_RST = 8'h2f;

	// unlock sequence
	localparam logic [ADDR_W-1:0] UNLOCK_ADDR1 = 21'h005555;
	localparam logic [ADDR_W-1:0] UNLOCK_ADDR2 = 21'h002aaa;
	localparam logic [DATA_W-1:0] DATA_AA      = 8'haa;
	localparam logic [DATA_W-1:0] DATA_55      = 8'h55;

	// commands
	localparam logic [DATA_W-1:0] CMD_ERASE   = 8'h30;
	localparam logic [DATA_W-1:0] CMD_SETUP   = 8'h80;
	localparam logic [DATA_W-1:0] CMD_ID      = 8'h90;
	localparam logic [DATA_W-1:0] CMD_PROTECT = 8'h9a;
	localparam logic [DATA_W-1:0] CMD_PROGRAM = 8'ha0;

	// device ids and boot-block region starts
	localparam logic [DATA_W-1:0] DEV_4M  = 8'hab;
	localparam logic [DATA_W-1:0] DEV_8M  = 8'h2c;
	localparam logic [DATA_W-1:0] DEV_16M = 8'h2f;
	localparam logic [ADDR_W-1:0] TOP_4M  = 21'h070000;
	localparam logic [ADDR_W-1:0] TOP_8M  = 21'h0f0000;
	localparam logic [ADDR_W-1:0] TOP_16M = 21'h1f0000;

	localparam logic [ADDR_W-1:0] MASK_32K = 21'h008000;
	localparam logic [ADDR_W-1:0] MASK_16K = 21'h00c000;
	localparam logic [ADDR_W-1:0] MASK_8K  = 21'h00e000;

	localparam logic [LEN_W-1:0] LEN_64K = 17'h10000;
	localparam logic [LEN_W-1:0] LEN_32K = 17'h08000;
	localparam logic [LEN_W-1:0] LEN_16K = 17'h04000;
	localparam logic [LEN_W-1:0] LEN_8K  = 17'h02000;

	typedef struct packed {
		logic [ADDR_W-1:0] write_address;
		logic [DATA_W-1:0] write_byte;
	} fcs_wr_t;

	typedef struct packed {
		mem_op_t           mem_op;
		logic [ADDR_W-1:0] op_address;
		logic [LEN_W-1:0]  erase_length;
		logic [DATA_W-1:0] op_byte;
		logic              id_overlay_on;
		state_t            sequence_state;
	} fcs_cmd_t;

endpackage

// File: sv/fcs_stream_if.sv
// Valid/ready stream interface, payload type given per instance.
// Used with the fcs_pkg payload structs.

interface fcs_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: sv/flash_command_sequencer.sv
// Flash command sequencer top level: unlock/command state machine and erase geometry.
// Depends on fcs_pkg and fcs_stream_if.

// Each bus-write transaction on wr yields exactly one command transaction on cmd.
// The block runs at one transaction per cycle while cmd is not stalled: a write
// is captured in an input register, decoded against the current sequence state
// by short logic and written, together with the state update, into an output
// register, from which the result is offered on cmd. The input register doubles
// as a skid stage: one more write is taken while a result waits on cmd.
// chip_present (index 0) and device_code (index 1) are written through the cfg
// port; the user must write them only while no transaction is in flight, as the
// block itself does not enforce this.
module flash_command_sequencer
	import fcs_pkg::*;
#(
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fcs_stream_if.sink            wr,
	fcs_stream_if.source          cmd,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration
	logic              chip_present_q;
	logic [DATA_W-1:0] device_code_q;

	// sequencer state
	state_t  state_q;
	prefix_t prefix_q;
	logic    overlay_q;

	// input register
	logic                    valid_s1;
	logic [ADDRESS_BITS-1:0] addr_s1;
	logic [DATA_W-1:0]       byte_s1;

	// output register
	logic     cmd_valid_q;
	fcs_cmd_t cmd_q;

	logic              adv;
	logic [ADDR_W-1:0] addr;
	state_t            ns;
	prefix_t           npfx;
	logic              novl;
	logic [ADDR_W-1:0] top;
	logic              known_dev;
	logic [ADDR_W-1:0] erase_base;
	logic [LEN_W-1:0]  erase_len;
	mem_op_t           op;
	logic [ADDR_W-1:0] op_addr;
	logic [LEN_W-1:0]  op_len;
	logic [DATA_W-1:0] op_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_present_q <= 1'b0;
			device_code_q  <= DEVICE_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CHIP_PRESENT: chip_present_q <= cfg_data[0];
				CFG_DEVICE_CODE:  device_code_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage advances into the output register when that is empty or being drained
	assign adv      = valid_s1 && (!cmd_valid_q || cmd.ready);
	assign wr.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (wr.valid && wr.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// address taken modulo the device's address space
	always_ff @(posedge clk) begin
		if (wr.valid && wr.ready) begin
			addr_s1 <= wr.payload.write_address[ADDRESS_BITS-1:0];
			byte_s1 <= wr.payload.write_byte;
		end
	end

	assign addr = ADDR_W'(addr_s1);

	// Next state, prefix and overlay
	always_comb begin
		ns   = ST_READ;
		npfx = prefix_q;
		novl = overlay_q;
		case (state_q)
			ST_READ, ST_ID: begin
				if (addr == UNLOCK_ADDR1 && byte_s1 == DATA_AA) ns = ST_UNLOCK1;
				npfx = PFX_NONE;
			end
			ST_UNLOCK1: begin
				if (addr == UNLOCK_ADDR2 && byte_s1 == DATA_55) ns = ST_UNLOCK2;
			end
			ST_UNLOCK2: begin
				// erase confirm is recognised at any address
				if (byte_s1 == CMD_ERASE) begin
					if (prefix_q == PFX_80) ns = ST_ERASED;
				end else if (addr == UNLOCK_ADDR1) begin
					case (byte_s1)
						CMD_SETUP: begin
							npfx = PFX_80;
							ns   = ST_COMMAND;
						end
						CMD_ID: begin
							novl = 1'b1;
							ns   = ST_ID;
						end
						CMD_PROTECT: begin
							if (prefix_q == PFX_9A) begin
								ns = ST_PROTECT;
							end else begin
								npfx = PFX_9A;
								ns   = ST_COMMAND;
							end
						end
						CMD_PROGRAM: ns = ST_PROGRAM;
						default: ;
					endcase
				end
			end
			ST_COMMAND: begin
				if (addr == UNLOCK_ADDR1 && byte_s1 == DATA_AA) ns = ST_UNLOCK1;
			end
			default: ;
		endcase
		// falling back to read drops the prefix and the ID overlay
		if (ns == ST_READ) begin
			npfx = PFX_NONE;
			novl = 1'b0;
		end
	end

	// Boot-block geometry: uniform 64KB blocks below the top region, then 32/8/8/16KB
	always_comb begin
		known_dev = 1'b1;
		case (device_code_q)
			DEV_4M:  top = TOP_4M;
			DEV_8M:  top = TOP_8M;
			DEV_16M: top = TOP_16M;
			default: begin
				top       = '0;
				known_dev = 1'b0;
			end
		endcase
		if (!known_dev) begin
			erase_base = '0;
			erase_len  = LEN_64K;
		end else if (addr < top) begin
			erase_base = addr & top;
			erase_len  = LEN_64K;
		end else if (addr[15]) begin
			if (addr[14]) begin
				erase_base = addr & (top | MASK_16K);
				erase_len  = LEN_16K;
			end else begin
				erase_base = addr & (top | MASK_8K);
				erase_len  = LEN_8K;
			end
		end else begin
			erase_base = addr & (top | MASK_32K);
			erase_len  = LEN_32K;
		end
	end

	// Memory command for this write
	always_comb begin
		op      = OP_NONE;
		op_addr = '0;
		op_len  = '0;
		op_byte = '0;
		if (chip_present_q) begin
			if (state_q == ST_UNLOCK2 && byte_s1 == CMD_ERASE && prefix_q == PFX_80) begin
				op      = OP_FILL;
				op_addr = erase_base;
				op_len  = erase_len;
			end else if (state_q == ST_PROGRAM) begin
				op      = OP_AND;
				op_addr = addr;
				op_byte = byte_s1;
			end
		end
	end

	// With the chip absent the state holds and the write issues no memory operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_READ;
			prefix_q  <= PFX_NONE;
			overlay_q <= 1'b0;
		end else if (adv && chip_present_q) begin
			state_q   <= ns;
			prefix_q  <= npfx;
			overlay_q <= novl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (adv) begin
			cmd_valid_q <= 1'b1;
		end else if (cmd.ready) begin
			cmd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_q.mem_op         <= op;
			cmd_q.op_address     <= op_addr;
			cmd_q.erase_length   <= op_len;
			cmd_q.op_byte        <= op_byte;
			cmd_q.id_overlay_on  <= chip_present_q ? novl : overlay_q;
			cmd_q.sequence_state <= chip_present_q ? ns : state_q;
		end
	end

	assign cmd.valid   = cmd_valid_q;
	assign cmd.payload = cmd_q;

endmodule

// File: sv/fcs_checker.sv
// Port-level checker for the flash command sequencer, with its bind statement.
// Depends on fcs_pkg and flash_command_sequencer.

module fcs_checker
	import fcs_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     cmd_valid,
	input logic     cmd_ready,
	input fcs_cmd_t cmd_payload
);

	// a stalled command transaction holds
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_payload))
		else $error("command changed while stalled");

	// an erase always lands in the erased state with a real length
	a_erase_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_payload.mem_op == OP_FILL |->
		cmd_payload.sequence_state == ST_ERASED && cmd_payload.erase_length != '0
		&& cmd_payload.op_byte == '0)
		else $error("erase command inconsistent");

	// no operation means all operation fields are zero
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_payload.mem_op == OP_NONE |->
		cmd_payload.op_address == '0 && cmd_payload.erase_length == '0
		&& cmd_payload.op_byte == '0)
		else $error("idle command carries operation fields");

	// the overlay is never left on in read state
	a_overlay_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_payload.id_overlay_on |-> cmd_payload.sequence_state != ST_READ)
		else $error("ID overlay on in read state");

endmodule

bind flash_command_sequencer fcs_checker u_fcs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_payload (cmd.payload)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for flash_command_sequencer: directed unlock and command
// sequences, then random bus-write traffic checked against an in-bench predictor.
// Depends on fcs_pkg, fcs_stream_if and the flash_command_sequencer RTL.

module testbench;
	import fcs_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fcs_stream_if #(.payload_t(fcs_wr_t))  wr_if ();
	fcs_stream_if #(.payload_t(fcs_cmd_t)) cmd_if ();

	flash_command_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr_if),
		.cmd       (cmd_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor copy of the configuration and sequencer state.
	logic       chip_on   = 1'b0;
	logic [7:0] dev_code  = DEVICE_CODE_RST;
	state_t     seq_state = ST_READ;
	prefix_t    pfx       = PFX_NONE;
	logic       overlay   = 1'b0;

	// Commands predicted for accepted writes, oldest first.
	fcs_cmd_t    due_commands[$];
	int unsigned mismatch_count = 0;
	int unsigned writes_sent    = 0;
	bit          no_gaps        = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net: a correct run ends far earlier than this.
	initial begin
		#(5_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Gap length: mostly none, often short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	// Erase block base and length for a 30 write, from the boot-block geometry.
	function automatic void erase_block(input logic [ADDR_W-1:0] a,
		output logic [ADDR_W-1:0] base, output logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] top;
		case (dev_code)
		DEV_4M: top = TOP_4M;
		DEV_8M: top = TOP_8M;
		DEV_16M: top = TOP_16M;
		default: top = '0;
		endcase
		if (top == '0) begin
			// unknown part: whole first 64KB
			base = '0;
			len  = LEN_64K;
		end else if (a < top) begin
			base = a & top;
			len  = LEN_64K;
		end else if (a[15] && a[14]) begin
			base = a & (top | MASK_16K);
			len  = LEN_16K;
		end else if (a[15]) begin
			base = a & (top | MASK_8K);
			len  = LEN_8K;
		end else begin
			base = a & (top | MASK_32K);
			len  = LEN_32K;
		end
	endfunction

	// Advance the predictor by one bus write and return the command it issues.
	function automatic fcs_cmd_t predict_command(input fcs_wr_t w);
		fcs_cmd_t          c;
		state_t            nxt;
		logic [ADDR_W-1:0] base;
		logic [LEN_W-1:0]  len;
		c = '0;
		if (chip_on) begin
			nxt = ST_READ;
			case (seq_state)
			ST_READ, ST_ID: begin
				if (w.write_address == UNLOCK_ADDR1 && w.write_byte == DATA_AA)
					nxt = ST_UNLOCK1;
				pfx = PFX_NONE;
			end
			ST_UNLOCK1: begin
				if (w.write_address == UNLOCK_ADDR2 && w.write_byte == DATA_55)
					nxt = ST_UNLOCK2;
			end
			ST_UNLOCK2: begin
				// 30 is decoded at any address; only an 80 prefix makes it an erase
				if (w.write_byte == CMD_ERASE) begin
					if (pfx == PFX_80) begin
						nxt = ST_ERASED;
						erase_block(w.write_address, base, len);
						c.mem_op       = OP_FILL;
						c.op_address   = base;
						c.erase_length = len;
					end
				end else if (w.write_address == UNLOCK_ADDR1) begin
					case (w.write_byte)
					CMD_SETUP: begin
						pfx = PFX_80;
						nxt = ST_COMMAND;
					end
					CMD_ID: begin
						overlay = 1'b1;
						nxt     = ST_ID;
					end
					CMD_PROTECT: begin
						if (pfx == PFX_9A) begin
							nxt = ST_PROTECT;
						end else begin
							pfx = PFX_9A;
							nxt = ST_COMMAND;
						end
					end
					CMD_PROGRAM: nxt = ST_PROGRAM;
					default: nxt = ST_READ;
					endcase
				end
			end
			ST_COMMAND: begin
				if (w.write_address == UNLOCK_ADDR1 && w.write_byte == DATA_AA)
					nxt = ST_UNLOCK1;
			end
			ST_PROGRAM: begin
				c.mem_op     = OP_AND;
				c.op_address = w.write_address;
				c.op_byte    = w.write_byte;
			end
			default: nxt = ST_READ;
			endcase
			seq_state = nxt;
			if (nxt == ST_READ) begin
				pfx     = PFX_NONE;
				overlay = 1'b0;
			end
		end
		c.id_overlay_on  = overlay;
		c.sequence_state = seq_state;
		return c;
	endfunction

	// One bus-write transaction; the prediction is queued at the accepting edge.
	task automatic send_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		int unsigned idle;
		fcs_wr_t     w;
		idle            = pick_gap();
		w.write_address = a;
		w.write_byte    = d;
		if (idle != 0) begin
			wr_if.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		wr_if.valid   <= 1'b1;
		wr_if.payload <= w;
		@(posedge clk);
		while (!wr_if.ready)
			@(posedge clk);
		due_commands.push_back(predict_command(w));
		writes_sent++;
	endtask

	task automatic send_unlock();
		send_write(UNLOCK_ADDR1, DATA_AA);
		send_write(UNLOCK_ADDR2, DATA_55);
	endtask

	// Stop writing, wait for every command, then let the pipeline go quiet.
	task automatic settle();
		wr_if.valid <= 1'b0;
		@(posedge clk);
		while (due_commands.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes both registers; only called once the block has settled.
	task automatic set_config(input logic present, input logic [7:0] code);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CHIP_PRESENT;
		cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, present};
		@(posedge clk);
		cfg_index <= CFG_DEVICE_CODE;
		cfg_data  <= code;
		@(posedge clk);
		cfg_we   <= 1'b0;
		chip_on  = present;
		dev_code = code;
	endtask

	function automatic logic [ADDR_W-1:0] pick_address();
		logic [ADDR_W-1:0] a;
		a = ADDR_W'($urandom);
		case ($urandom_range(0, 9))
		0: a = UNLOCK_ADDR1;
		1: a = UNLOCK_ADDR2;
		2: a = '0;
		3: a = '1;
		// boot-block regions of all three parts, so every geometry branch is hit
		4: a = TOP_4M | {5'd0, a[15:0]};
		5: a = TOP_8M | {5'd0, a[15:0]};
		6: a = TOP_16M | {5'd0, a[15:0]};
		default: a = a;
		endcase
		return a;
	endfunction

	function automatic logic [DATA_W-1:0] pick_byte();
		case ($urandom_range(0, 13))
		0: return DATA_AA;
		1: return DATA_55;
		2: return CMD_ERASE;
		3: return CMD_SETUP;
		4: return CMD_ID;
		5: return CMD_PROTECT;
		6: return CMD_PROGRAM;
		default: return DATA_W'($urandom);
		endcase
	endfunction

	// Result checker: every cmd transaction against the oldest prediction.
	always @(posedge clk) begin
		fcs_cmd_t got;
		fcs_cmd_t want;
		if (arst_n && cmd_if.valid && cmd_if.ready) begin
			got = cmd_if.payload;
			if (due_commands.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected command op=%0d addr=%h len=%h byte=%h",
						$realtime, got.mem_op, got.op_address, got.erase_length,
						got.op_byte);
			end else begin
				want = due_commands.pop_front();
				if (got.mem_op !== want.mem_op || got.op_address !== want.op_address ||
					got.erase_length !== want.erase_length ||
					got.op_byte !== want.op_byte ||
					got.id_overlay_on !== want.id_overlay_on ||
					got.sequence_state !== want.sequence_state) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: command mismatch", $realtime);
						$display("  got  op=%0d addr=%h len=%h byte=%h ovl=%b st=%0d",
							got.mem_op, got.op_address, got.erase_length, got.op_byte,
							got.id_overlay_on, got.sequence_state);
						$display("  want op=%0d addr=%h len=%h byte=%h ovl=%b st=%0d",
							want.mem_op, want.op_address, want.erase_length,
							want.op_byte, want.id_overlay_on, want.sequence_state);
					end
				end
			end
		end
	end

	// cmd back-pressure: random stalls of mixed length, none while no_gaps is set.
	initial begin
		int unsigned hold;
		hold = 0;
		cmd_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold != 0) begin
				cmd_if.ready <= 1'b0;
				hold--;
			end else begin
				cmd_if.ready <= 1'b1;
				hold = pick_gap();
			end
		end
	end

	// Chip absent after reset: no memory operation issues, state stays in read.
	task automatic test_chip_absent();
		send_write(UNLOCK_ADDR1, DATA_AA);
		send_write('0, 8'hff);
	endtask

	// Program at the top address with a zero byte.
	task automatic test_program();
		send_unlock();
		send_write(UNLOCK_ADDR1, CMD_PROGRAM);
		send_write('1, 8'h00);
	endtask

	// 30 without the 80 prefix falls back to read, at a non-unlock address too.
	task automatic test_erase_no_prefix();
		send_unlock();
		send_write(21'h001234, CMD_ERASE);
	endtask

	// Unknown command at 5555, then a valid command at the wrong address.
	task automatic test_bad_commands();
		send_unlock();
		send_write(UNLOCK_ADDR1, 8'h12);
		send_unlock();
		send_write(21'h001234, CMD_SETUP);
	endtask

	// ID mode sets the overlay; a stray write leaves it and clears it.
	task automatic test_id_mode();
		send_unlock();
		send_write(UNLOCK_ADDR1, CMD_ID);
		send_write(UNLOCK_ADDR2, 8'hff);
	endtask

	// Full erase sequence in the 16Mbit top region, 16KB block.
	task automatic test_erase();
		send_unlock();
		send_write(UNLOCK_ADDR1, CMD_SETUP);
		send_unlock();
		send_write('1, CMD_ERASE);
	endtask

	// Double 9A reaches protect; the first write leaves the erased state.
	task automatic test_protect();
		send_write(UNLOCK_ADDR2, DATA_55);
		send_unlock();
		send_write(UNLOCK_ADDR1, CMD_PROTECT);
		send_unlock();
		send_write(UNLOCK_ADDR1, CMD_PROTECT);
	endtask

	// Mostly well-formed command sequences with random content, some noise.
	task automatic random_burst(input int unsigned count);
		int unsigned stop_at;
		int unsigned n;
		stop_at = writes_sent + count;
		while (writes_sent < stop_at) begin
			case ($urandom_range(0, 9))
			0, 1: begin
				send_unlock();
				send_write(UNLOCK_ADDR1, CMD_SETUP);
				send_unlock();
				send_write(pick_address(), CMD_ERASE);
			end
			2, 3: begin
				send_unlock();
				send_write(UNLOCK_ADDR1, CMD_PROGRAM);
				send_write(pick_address(), DATA_W'($urandom));
			end
			4: begin
				send_unlock();
				send_write(UNLOCK_ADDR1, CMD_ID);
				n = $urandom_range(1, 3);
				repeat (n) send_write(pick_address(), pick_byte());
			end
			5: begin
				send_unlock();
				send_write(UNLOCK_ADDR1, CMD_PROTECT);
				send_unlock();
				send_write(UNLOCK_ADDR1, CMD_PROTECT);
				send_write(pick_address(), pick_byte());
			end
			6: begin
				// prefix replaced by 9A before the 30
				send_unlock();
				send_write(UNLOCK_ADDR1, CMD_SETUP);
				send_unlock();
				send_write(UNLOCK_ADDR1, CMD_PROTECT);
				send_unlock();
				send_write(pick_address(), CMD_ERASE);
			end
			7: begin
				// broken unlock
				send_write(UNLOCK_ADDR1, DATA_AA);
				send_write(pick_address(), pick_byte());
				send_write(pick_address(), pick_byte());
			end
			default: send_write(pick_address(), pick_byte());
			endcase
		end
	endtask

	task automatic test_random_traffic();
		settle();
		set_config(1'b1, DEV_16M);
		random_burst(80);
		settle();
		set_config(1'b1, DEV_4M);
		random_burst(60);
		settle();
		set_config(1'b1, DEV_8M);
		no_gaps = 1'b1;
		random_burst(50);
		no_gaps = 1'b0;
		settle();
		set_config(1'b1, 8'h00);
		random_burst(40);
		settle();
		set_config(1'b1, 8'hff);
		random_burst(40);
		settle();
		set_config(1'b1, 8'($urandom));
		random_burst(40);
		settle();
		set_config(1'b0, 8'($urandom));
		random_burst(30);
		settle();
		set_config(1'b1, DEV_16M);
		random_burst(60);
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_CHIP_PRESENT;
		cfg_data      <= '0;
		wr_if.valid   <= 1'b0;
		wr_if.payload <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: default configuration first, chip absent
		test_chip_absent();
		settle();
		set_config(1'b1, DEV_16M);
		test_program();
		test_erase_no_prefix();
		test_bad_commands();
		test_id_mode();
		test_erase();
		test_protect();

		test_random_traffic();

		// drain everything, then a few quiet cycles
		settle();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0 && due_commands.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
